@@ sv/dfi_pkg.sv @@
// Shared types and constants for the depth-to-focus interpolator.
// Used by dfi_divider and depth_to_focus_interpolator; depends on nothing.
package dfi_pkg;

  localparam int DEPTH_W = 24;
  localparam int MOTOR_W = 12;
  localparam int CNT_W   = 7;
  localparam int REQ_W   = 2;
  localparam int STAT_W  = 2;
  localparam int PROD_W  = DEPTH_W + MOTOR_W;

  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [MOTOR_W-1:0] motor;
  } point_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_QFIRST,
    S_QLAST,
    S_QSCAN,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

endpackage

@@ sv/depth_to_focus_interpolator.sv @@
// Depth-to-focus interpolator top level; depends on dfi_pkg and dfi_divider.
// Clear, unused request codes, empty queries and full inserts go straight to the result;
// an insert first shifts each deeper entry up one slot; a query reads the first entry, then
// the last if needed, then one table read per scan step, then 12 divider steps.
// Throughput: one transaction in flight; the next is accepted once the result sits in the
// output register. Reset: synchronous, active low; the table empties with no clearing pass.
module depth_to_focus_interpolator #(
  parameter int MAX_POINTS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dfi_pkg::REQ_W-1:0]    in_req_type,
  input  logic [dfi_pkg::DEPTH_W-1:0]  in_depth_um,
  input  logic [dfi_pkg::MOTOR_W-1:0]  in_motor_pos,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dfi_pkg::MOTOR_W-1:0]  out_focus_pos,
  output logic [dfi_pkg::STAT_W-1:0]   out_status,
  output logic [dfi_pkg::CNT_W-1:0]    out_entries_held
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = dfi_pkg::CNT_W;

  // The breakpoint table lives in one synchronous memory, sorted by depth.
  // Only the first count_r entries are ever used, so it needs no reset.
  dfi_pkg::point_t mem [MAX_POINTS];
  dfi_pkg::point_t rd_data_r;
  logic            wr_en;
  logic [IDX_W-1:0] wr_addr;
  dfi_pkg::point_t  wr_data;
  logic [IDX_W-1:0] rd_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  dfi_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]            pos_r, pos_nxt;
  logic [IDX_W-1:0]            j_r, j_nxt;
  logic [dfi_pkg::DEPTH_W-1:0] d_r, d_nxt;
  logic [dfi_pkg::MOTOR_W-1:0] m_r, m_nxt;
  logic [dfi_pkg::DEPTH_W-1:0] prev_d_r, prev_d_nxt;
  logic [dfi_pkg::MOTOR_W-1:0] prev_m_r, prev_m_nxt;
  logic [dfi_pkg::DEPTH_W-1:0] offs_r, offs_nxt;
  logic [dfi_pkg::DEPTH_W-1:0] span_r, span_nxt;
  logic [dfi_pkg::MOTOR_W-1:0] dmag_r, dmag_nxt;
  logic                        neg_r, neg_nxt;
  logic [dfi_pkg::MOTOR_W-1:0] res_focus_r, res_focus_nxt;
  logic [dfi_pkg::STAT_W-1:0]  res_status_r, res_status_nxt;
  logic [dfi_pkg::MOTOR_W-1:0] out_focus_r, out_focus_nxt;
  logic [dfi_pkg::STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [CNT_W-1:0]            out_entries_r, out_entries_nxt;

  logic                        div_start;
  logic                        div_done;
  logic [dfi_pkg::MOTOR_W-1:0] div_quot;
  logic [dfi_pkg::PROD_W-1:0]  product;
  logic [dfi_pkg::DEPTH_W-1:0] span_now;
  logic [dfi_pkg::MOTOR_W+1:0] sum;

  // The multiplier feeds the divider's input registers directly.
  assign product = offs_r * dmag_r;

  dfi_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (product),
    .divisor  (span_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign span_now = rd_data_r.depth - prev_d_r;

  // The quotient never exceeds the motor step, so the sum stays inside the two
  // end points; the clamp below only guards the range.
  assign sum = neg_r ? ({2'b00, prev_m_r} - {2'b00, div_quot})
                     : ({2'b00, prev_m_r} + {2'b00, div_quot});

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    out_valid_nxt   = out_valid_r;
    pos_nxt         = pos_r;
    j_nxt           = j_r;
    d_nxt           = d_r;
    m_nxt           = m_r;
    prev_d_nxt      = prev_d_r;
    prev_m_nxt      = prev_m_r;
    offs_nxt        = offs_r;
    span_nxt        = span_r;
    dmag_nxt        = dmag_r;
    neg_nxt         = neg_r;
    res_focus_nxt   = res_focus_r;
    res_status_nxt  = res_status_r;
    out_focus_nxt   = out_focus_r;
    out_status_nxt  = out_status_r;
    out_entries_nxt = out_entries_r;
    in_ready        = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = pos_r;
    wr_data         = rd_data_r;
    rd_addr         = '0;
    div_start       = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      dfi_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          d_nxt          = in_depth_um;
          m_nxt          = in_motor_pos;
          res_focus_nxt  = '0;
          res_status_nxt = dfi_pkg::STAT_OK;
          state_nxt      = dfi_pkg::S_DONE;
          case (in_req_type)
            dfi_pkg::REQ_CLEAR: begin
              count_nxt = '0;
            end
            dfi_pkg::REQ_INSERT: begin
              if (count_r >= CNT_W'(MAX_POINTS)) begin
                res_status_nxt = dfi_pkg::STAT_FULL;
              end else begin
                // Walk down from the free slot, reading the entry just below it.
                pos_nxt   = IDX_W'(count_r);
                rd_addr   = IDX_W'(count_r - CNT_W'(1));
                state_nxt = dfi_pkg::S_INSERT;
              end
            end
            dfi_pkg::REQ_QUERY: begin
              if (count_r == '0) begin
                res_status_nxt = dfi_pkg::STAT_EMPTY;
              end else begin
                rd_addr   = '0;
                state_nxt = dfi_pkg::S_QFIRST;
              end
            end
            default: begin
            end
          endcase
        end
      end

      dfi_pkg::S_INSERT: begin
        // rd_data_r holds the entry just below pos_r. A deeper entry moves up
        // one slot; an equal one stays, so a new point lands after its equals.
        wr_en   = 1'b1;
        wr_addr = pos_r;
        if ((pos_r != '0) && (rd_data_r.depth > d_r)) begin
          wr_data = rd_data_r;
          pos_nxt = pos_r - IDX_W'(1);
          rd_addr = pos_r - IDX_W'(2);
        end else begin
          wr_data.depth = d_r;
          wr_data.motor = m_r;
          count_nxt     = count_r + CNT_W'(1);
          state_nxt     = dfi_pkg::S_DONE;
        end
      end

      dfi_pkg::S_QFIRST: begin
        // At or below the first depth, or a single point: hold the first position.
        if ((d_r <= rd_data_r.depth) || (count_r == CNT_W'(1))) begin
          res_focus_nxt = rd_data_r.motor;
          state_nxt     = dfi_pkg::S_DONE;
        end else begin
          prev_d_nxt = rd_data_r.depth;
          prev_m_nxt = rd_data_r.motor;
          rd_addr    = IDX_W'(count_r - CNT_W'(1));
          state_nxt  = dfi_pkg::S_QLAST;
        end
      end

      dfi_pkg::S_QLAST: begin
        // At or beyond the last depth, duplicates included: hold the last position.
        if (d_r >= rd_data_r.depth) begin
          res_focus_nxt = rd_data_r.motor;
          state_nxt     = dfi_pkg::S_DONE;
        end else begin
          j_nxt     = IDX_W'(1);
          rd_addr   = IDX_W'(1);
          state_nxt = dfi_pkg::S_QSCAN;
        end
      end

      dfi_pkg::S_QSCAN: begin
        // rd_data_r is entry j_r; prev holds entry j_r - 1, which is below the query.
        // The query lies below the last depth, so the scan ends at the last entry at most.
        if (rd_data_r.depth >= d_r) begin
          if (span_now < dfi_pkg::DEPTH_W'(2)) begin
            res_focus_nxt = prev_m_r;
            state_nxt     = dfi_pkg::S_DONE;
          end else begin
            offs_nxt  = d_r - prev_d_r;
            span_nxt  = span_now;
            neg_nxt   = (rd_data_r.motor < prev_m_r);
            dmag_nxt  = (rd_data_r.motor < prev_m_r) ? (prev_m_r - rd_data_r.motor)
                                                     : (rd_data_r.motor - prev_m_r);
            state_nxt = dfi_pkg::S_MUL;
          end
        end else begin
          prev_d_nxt = rd_data_r.depth;
          prev_m_nxt = rd_data_r.motor;
          j_nxt      = j_r + IDX_W'(1);
          rd_addr    = j_r + IDX_W'(1);
        end
      end

      dfi_pkg::S_MUL: begin
        div_start = 1'b1;
        state_nxt = dfi_pkg::S_DIV;
      end

      dfi_pkg::S_DIV: begin
        if (div_done) begin
          if (sum[dfi_pkg::MOTOR_W+1]) begin
            res_focus_nxt = '0;
          end else if (sum[dfi_pkg::MOTOR_W]) begin
            res_focus_nxt = '1;
          end else begin
            res_focus_nxt = sum[dfi_pkg::MOTOR_W-1:0];
          end
          state_nxt = dfi_pkg::S_DONE;
        end
      end

      dfi_pkg::S_DONE: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_focus_nxt   = res_focus_r;
          out_status_nxt  = res_status_r;
          out_entries_nxt = count_r;
          state_nxt       = dfi_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = dfi_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dfi_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r         <= pos_nxt;
    j_r           <= j_nxt;
    d_r           <= d_nxt;
    m_r           <= m_nxt;
    prev_d_r      <= prev_d_nxt;
    prev_m_r      <= prev_m_nxt;
    offs_r        <= offs_nxt;
    span_r        <= span_nxt;
    dmag_r        <= dmag_nxt;
    neg_r         <= neg_nxt;
    res_focus_r   <= res_focus_nxt;
    res_status_r  <= res_status_nxt;
    out_focus_r   <= out_focus_nxt;
    out_status_r  <= out_status_nxt;
    out_entries_r <= out_entries_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_focus_pos    = out_focus_r;
  assign out_status       = out_status_r;
  assign out_entries_held = out_entries_r;

`ifndef SYNTH
  // The table never holds more points than it has room for.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_POINTS))
    else $error("breakpoint count exceeds table size");

  // An accepted clear empties the table by the next edge.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_req_type == dfi_pkg::REQ_CLEAR)) |=> (count_r == '0))
    else $error("clear did not empty the table");

  // The divider only finishes while the sequencer is waiting for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == dfi_pkg::S_DIV))
    else $error("divider finished outside the divide step");

  // A full-table insert leaves the count unchanged.
  a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_req_type == dfi_pkg::REQ_INSERT) &&
     (count_r == CNT_W'(MAX_POINTS))) |=> $stable(count_r))
    else $error("insert into a full table changed the count");
`endif

endmodule

@@ sv/dfi_divider.sv @@
// Restoring divider for the interpolation step, one quotient bit per cycle.
// Depends on dfi_pkg; the caller guarantees dividend < divisor * 2**MOTOR_W.
module dfi_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [dfi_pkg::PROD_W-1:0]  dividend,
  input  logic [dfi_pkg::DEPTH_W-1:0] divisor,
  output logic                        done,
  output logic [dfi_pkg::MOTOR_W-1:0] quotient
);

  localparam int STEP_W = $clog2(dfi_pkg::MOTOR_W + 1);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [STEP_W-1:0]           step_r, step_nxt;
  logic [dfi_pkg::DEPTH_W-1:0] rem_r, rem_nxt;
  logic [dfi_pkg::DEPTH_W-1:0] den_r, den_nxt;
  logic [dfi_pkg::MOTOR_W-1:0] low_r, low_nxt;
  logic [dfi_pkg::MOTOR_W-1:0] quot_r, quot_nxt;
  logic [dfi_pkg::DEPTH_W:0]   shifted;
  logic [dfi_pkg::DEPTH_W:0]   trial;

  assign shifted = {rem_r, low_r[dfi_pkg::MOTOR_W-1]};
  assign trial   = shifted - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    low_nxt  = low_r;
    quot_nxt = quot_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(dfi_pkg::MOTOR_W);
      rem_nxt  = dividend[dfi_pkg::PROD_W-1:dfi_pkg::MOTOR_W];
      low_nxt  = dividend[dfi_pkg::MOTOR_W-1:0];
      den_nxt  = divisor;
    end else if (busy_r) begin
      if (!trial[dfi_pkg::DEPTH_W]) begin
        rem_nxt  = trial[dfi_pkg::DEPTH_W-1:0];
        quot_nxt = {quot_r[dfi_pkg::MOTOR_W-2:0], 1'b1};
      end else begin
        rem_nxt  = shifted[dfi_pkg::DEPTH_W-1:0];
        quot_nxt = {quot_r[dfi_pkg::MOTOR_W-2:0], 1'b0};
      end
      low_nxt  = {low_r[dfi_pkg::MOTOR_W-2:0], 1'b0};
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    low_r  <= low_nxt;
    quot_r <= quot_nxt;
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule
